/* src/dsdc_pkg.sv */
// shared constants, types and modular arithmetic for the digit sum divisibility counter
package dsdc_pkg;

    // table geometry
    localparam int MAX_DIVISOR = 128;
    localparam int IDX_W       = $clog2(MAX_DIVISOR);
    localparam int DIV_W       = $clog2(MAX_DIVISOR + 1);
    localparam int BANK_AW     = IDX_W + 1;
    localparam int RAM_DEPTH   = 2 * MAX_DIVISOR;

    // count arithmetic
    localparam int CNT_W = 30;
    localparam logic [CNT_W-1:0] MODP = 30'd1000000007;

    // decimal digits
    localparam int RADIX = 10;
    localparam logic [3:0] DIGIT_MAX = 4'(RADIX - 1);

    // register indexes
    localparam logic REG_DIVISOR = 1'b0;

    typedef logic [CNT_W-1:0] t_cnt;

    // one write port and two read ports on a table memory
    typedef struct packed {
        logic               we;
        logic [BANK_AW-1:0] waddr;
        t_cnt               wdata;
        logic [BANK_AW-1:0] raddr_a;
        logic [BANK_AW-1:0] raddr_b;
    } t_ram_req;

    typedef struct packed {
        t_cnt rdata_a;
        t_cnt rdata_b;
    } t_ram_rsp;

    // (a + b) mod p, both operands below p
    function automatic t_cnt add_mod(input t_cnt a, input t_cnt b);
        logic [CNT_W:0] s;
        logic [CNT_W:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, MODP};
        return (s >= {1'b0, MODP}) ? d[CNT_W-1:0] : s[CNT_W-1:0];
    endfunction

    // (a - b) mod p, both operands below p
    function automatic t_cnt sub_mod(input t_cnt a, input t_cnt b);
        logic [CNT_W:0] d;
        logic [CNT_W:0] w;
        d = {1'b0, a} - {1'b0, b};
        w = d + {1'b0, MODP};
        return (a >= b) ? d[CNT_W-1:0] : w[CNT_W-1:0];
    endfunction

endpackage

/* src/digit_sum_divisible_counter_top.sv */
// digit dp counter of integers up to a decimal prefix whose digit sum divides evenly
//
//  channel   | direction | beat contents
//  ----------+-----------+-------------------------------------------------------
//  s_axis    | in        | tdata[3:0] digit, tuser[0] first_digit
//  m_axis    | out       | tdata[29:0] count
//  apb       | in        | register 0 at byte address 0: divisor (8 bits)
//
// each digit is worked in order: ten priming steps fill the sliding window sums, then
// d residues, d = effective divisor (1..128), are issued one after another through the
// shared read / subtract / accumulate / add pipeline on the dual-read table memories,
// the pipeline drains and the count is formed; the next digit is taken after the result
// is loaded into the output register.
// s_axis_tready is high only between digits; a result waits in the output register
// while the next digit is taken, and the block stalls before loading a new result.
// i_rst_n is synchronous: tables read as cleared (entry 0 of the tight table is one),
// divisor is one. there is no clearing pass.
module digit_sum_divisible_counter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input digits
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] digit, [7:4] zero
    input  logic [0:0]  s_axis_tuser,   // [0] first_digit
    // output counts
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [29:0] count, [31:30] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dsdc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FIN1  = 3'd4;
    localparam logic [2:0] S_FIN2  = 3'd5;

    // sequencer and configuration
    logic [2:0]       r_state, n_state;
    logic [7:0]       r_divisor;
    logic             r_bank;
    logic [DIV_W-1:0] r_fill [2];
    logic [DIV_W-1:0] r_d;
    logic [3:0]       r_dig;
    logic [3:0]       r_k;
    logic [IDX_W-1:0] r_q;
    logic [IDX_W-1:0] r_pt;
    logic [IDX_W-1:0] r_pb;
    logic [DIV_W-1:0] r_r;

    // pipeline stage after the memory read
    logic             r_p1_v, r_p1_run, r_p1_use_t, r_p1_first;
    logic [IDX_W-1:0] r_p1_idx;
    logic             r_p1_va, r_p1_za, r_p1_vbt, r_p1_zbt, r_p1_vbb;
    // delta stage
    logic             r_p2_v, r_p2_run;
    logic [IDX_W-1:0] r_p2_idx;
    t_cnt             r_p2_dt, r_p2_db, r_p2_nt;
    // write stage
    logic             r_p3_v;
    logic [IDX_W-1:0] r_p3_idx;
    t_cnt             r_p3_nt;

    // window sums and final count
    t_cnt r_wt, r_wb;
    t_cnt r_nt0, r_nb0;
    t_cnt r_sum;
    logic r_out_valid;
    t_cnt r_out_count;

    logic             s_accept;
    logic             cfg_write;
    logic [DIV_W-1:0] d_eff;
    logic [3:0]       dig_sat;
    logic [DIV_W-1:0] fill_cur;
    logic             issue_v;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] q_next;
    logic             last_init;
    logic             last_run;
    logic             pipe_empty;
    logic             out_load;
    t_ram_req         tight_req, below_req;
    t_ram_rsp         tight_rsp, below_rsp;
    t_cnt             ta, tb, ba, bb;
    t_cnt             nb;
    t_cnt             count_c;

    // handshakes
    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DIVISOR) ? {24'd0, r_divisor} : 32'd0;

    // effective divisor and saturated digit
    always_comb begin
        if (r_divisor == 8'd0) begin
            d_eff = DIV_W'(1);
        end else if ({24'd0, r_divisor} > 32'(MAX_DIVISOR)) begin
            d_eff = DIV_W'(MAX_DIVISOR);
        end else begin
            d_eff = DIV_W'(r_divisor);
        end
    end
    assign dig_sat  = (s_axis_tdata[3:0] > DIGIT_MAX) ? DIGIT_MAX : s_axis_tdata[3:0];
    assign fill_cur = r_fill[r_bank];

    // read issue
    assign issue_v    = (r_state == S_INIT) || (r_state == S_RUN);
    assign idx_a      = (r_state == S_INIT) ? r_q : r_r[IDX_W-1:0];
    assign q_next     = (r_q == '0) ? IDX_W'(r_d - DIV_W'(1)) : r_q - IDX_W'(1);
    assign last_init  = (r_k == DIGIT_MAX);
    assign last_run   = (r_r == r_d - DIV_W'(1));
    assign pipe_empty = !r_p1_v && !r_p2_v && !r_p3_v;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_accept) n_state = S_INIT;
            S_INIT:  if (last_init) n_state = S_RUN;
            S_RUN:   if (last_run) n_state = S_DRAIN;
            S_DRAIN: if (pipe_empty) n_state = S_FIN1;
            S_FIN1:  n_state = S_FIN2;
            S_FIN2:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_divisor <= 8'd1;
            r_bank    <= 1'b0;
            r_fill[0] <= '0;
            r_fill[1] <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_write && paddr[2] == REG_DIVISOR) begin
                r_divisor <= pwdata[7:0];
            end
            // a new number starts from the cleared tables
            if (s_accept && s_axis_tuser[0]) begin
                r_fill[r_bank] <= '0;
            end
            // new tables become live once the last write is done
            if (r_state == S_DRAIN && pipe_empty) begin
                r_fill[~r_bank] <= r_d;
                r_bank          <= ~r_bank;
            end
        end
    end

    // counters and window pointers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_d   <= d_eff;
            r_dig <= dig_sat;
            r_k   <= 4'd0;
            r_q   <= '0;
            r_r   <= '0;
        end
        if (r_state == S_INIT) begin
            r_k <= r_k + 4'd1;
            r_q <= q_next;
            if (r_k == r_dig) begin
                r_pt <= r_q;
            end
            if (last_init) begin
                r_pb <= q_next;
            end
        end
        if (r_state == S_RUN) begin
            r_r  <= r_r + DIV_W'(1);
            r_pt <= (r_pt == IDX_W'(r_d - DIV_W'(1))) ? '0 : r_pt + IDX_W'(1);
            r_pb <= (r_pb == IDX_W'(r_d - DIV_W'(1))) ? '0 : r_pb + IDX_W'(1);
        end
    end

    // table memories: read the live bank, write the other
    always_comb begin
        tight_req.we      = r_p3_v;
        tight_req.waddr   = {~r_bank, r_p3_idx};
        tight_req.wdata   = r_p3_nt;
        tight_req.raddr_a = {r_bank, idx_a};
        tight_req.raddr_b = {r_bank, r_pt};
        below_req.we      = r_p3_v;
        below_req.waddr   = {~r_bank, r_p3_idx};
        below_req.wdata   = nb;
        below_req.raddr_a = {r_bank, idx_a};
        below_req.raddr_b = {r_bank, r_pb};
    end

    dsdc_ram u_tight (
        .i_clk (i_clk),
        .i_req (tight_req),
        .o_rsp (tight_rsp)
    );

    dsdc_ram u_below (
        .i_clk (i_clk),
        .i_req (below_req),
        .o_rsp (below_rsp)
    );

    // read tags, registered alongside the memory data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else begin
            r_p1_v <= issue_v;
        end
        r_p1_run   <= (r_state == S_RUN);
        r_p1_use_t <= (r_k < r_dig);
        r_p1_first <= (r_r == '0);
        r_p1_idx   <= idx_a;
        r_p1_va    <= DIV_W'(idx_a) < fill_cur;
        r_p1_za    <= (idx_a == '0);
        r_p1_vbt   <= DIV_W'(r_pt) < fill_cur;
        r_p1_zbt   <= (r_pt == '0);
        r_p1_vbb   <= DIV_W'(r_pb) < fill_cur;
    end

    // entries past the fill count read as the cleared tables
    assign ta = r_p1_va  ? tight_rsp.rdata_a : (r_p1_za  ? t_cnt'(1) : '0);
    assign tb = r_p1_vbt ? tight_rsp.rdata_b : (r_p1_zbt ? t_cnt'(1) : '0);
    assign ba = r_p1_va  ? below_rsp.rdata_a : '0;
    assign bb = r_p1_vbb ? below_rsp.rdata_b : '0;

    // delta stage: window step, or a priming term
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else begin
            r_p2_v <= r_p1_v;
        end
        r_p2_run <= r_p1_run;
        r_p2_idx <= r_p1_idx;
        r_p2_nt  <= tb;
        if (r_p1_run) begin
            r_p2_dt <= r_p1_first ? '0 : sub_mod(ta, tb);
            r_p2_db <= r_p1_first ? '0 : sub_mod(ba, bb);
        end else begin
            r_p2_dt <= r_p1_use_t ? ta : '0;
            r_p2_db <= ba;
        end
    end

    // accumulate window sums
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_wt <= '0;
            r_wb <= '0;
        end else if (r_p2_v) begin
            r_wt <= add_mod(r_wt, r_p2_dt);
            r_wb <= add_mod(r_wb, r_p2_db);
        end
    end

    // write stage
    assign nb = add_mod(r_wt, r_wb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_v <= 1'b0;
        end else begin
            r_p3_v <= r_p2_v && r_p2_run;
        end
        r_p3_idx <= r_p2_idx;
        r_p3_nt  <= r_p2_nt;
        if (r_p3_v && r_p3_idx == '0) begin
            r_nt0 <= r_p3_nt;
            r_nb0 <= nb;
        end
    end

    // final count, zero removed
    assign count_c  = (r_sum == '0) ? MODP - t_cnt'(1) : r_sum - t_cnt'(1);
    assign out_load = (r_state == S_FIN2) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN1) begin
            r_sum <= add_mod(r_nt0, r_nb0);
        end
        if (out_load) begin
            r_out_count <= count_c;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_count};

endmodule

/* src/dsdc_ram.sv */
// two-bank residue table memory, one write port and two registered read ports
module dsdc_ram (
    input  logic               i_clk,
    input  dsdc_pkg::t_ram_req i_req,
    output dsdc_pkg::t_ram_rsp o_rsp
);
    import dsdc_pkg::*;

    t_cnt r_mem [RAM_DEPTH];
    t_cnt r_rdata_a;
    t_cnt r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_req.raddr_a];
        r_rdata_b <= r_mem[i_req.raddr_b];
    end

    assign o_rsp.rdata_a = r_rdata_a;
    assign o_rsp.rdata_b = r_rdata_b;

endmodule

/* src/dsdc_checker.sv */
// port-level checks for the digit sum divisible counter, bound to the top level
module dsdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    import dsdc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // one digit at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again while a digit is in work");

    // a new result only comes out of a busy period
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a digit in work");

    // counts stay reduced
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata < {2'b00, MODP})
        else $error("count not reduced modulo p");

endmodule

bind digit_sum_divisible_counter_top dsdc_checker u_dsdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
